/* src/chacha_pkg.sv */
// Shared types, constants and register indexes for the ChaCha20 stream cipher.
package chacha_pkg;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] block_t;

    localparam word_t SIGMA_0 = 32'h61707865;
    localparam word_t SIGMA_1 = 32'h3320646e;
    localparam word_t SIGMA_2 = 32'h79622d32;
    localparam word_t SIGMA_3 = 32'h6b206574;

    localparam int NUM_ROUNDS = 20;
    localparam int ROUND_W    = $clog2(NUM_ROUNDS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COUNTER = 3'd6;

endpackage

/* src/chacha_if.sv */
// Handshake interfaces for the plaintext, ciphertext and configuration channels.
interface chacha_in_if;
    logic                        valid;
    logic                        ready;
    logic [31:0]                 data_in;
    logic [chacha_pkg::CNT_W-1:0] byte_count;
    logic                        last_item;

    modport source (output valid, data_in, byte_count, last_item, input ready);
    modport sink (input valid, data_in, byte_count, last_item, output ready);
endinterface

interface chacha_out_if;
    logic                        valid;
    logic                        ready;
    logic [31:0]                 data_out;
    logic [chacha_pkg::CNT_W-1:0] byte_count_out;
    logic                        last_out;

    modport source (output valid, data_out, byte_count_out, last_out, input ready);
    modport sink (input valid, data_out, byte_count_out, last_out, output ready);
endinterface

interface chacha_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [chacha_pkg::CFG_IDX_W-1:0]  index;
    logic [chacha_pkg::CFG_DATA_W-1:0] value;

    modport source (output valid, index, value, input ready);
    modport sink (input valid, index, value, output ready);
endinterface

/* src/chacha_round.sv */
// Half of a ChaCha20 round: four quarter-round halves over columns or diagonals.
module chacha_round (
    input  chacha_pkg::block_t x_in,
    input  logic               diag,
    input  logic               second_half,
    output chacha_pkg::block_t x_out
);

    always_comb
    begin
        automatic logic [3:0] ia;
        automatic logic [3:0] ib;
        automatic logic [3:0] ic;
        automatic logic [3:0] id;
        automatic chacha_pkg::word_t a1;
        automatic chacha_pkg::word_t dx;
        automatic chacha_pkg::word_t d1;
        automatic chacha_pkg::word_t c1;
        automatic chacha_pkg::word_t bx;
        automatic chacha_pkg::word_t b1;
        x_out = x_in;
        for (int i = 0; i < 4; i++)
        begin
            ia = 4'(i);
            ib = diag ? 4'(4 + ((i + 1) & 3)) : 4'(4 + i);
            ic = diag ? 4'(8 + ((i + 2) & 3)) : 4'(8 + i);
            id = diag ? 4'(12 + ((i + 3) & 3)) : 4'(12 + i);
            a1 = x_in[ia] + x_in[ib];
            dx = x_in[id] ^ a1;
            d1 = second_half ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
            c1 = x_in[ic] + d1;
            bx = x_in[ib] ^ c1;
            b1 = second_half ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
            x_out[ia] = a1;
            x_out[ib] = b1;
            x_out[ic] = c1;
            x_out[id] = d1;
        end
    end

endmodule

/* src/chacha_block_gen.sv */
// Keystream block generator that reuses one round unit under a small sequencer.
module chacha_block_gen (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  chacha_pkg::block_t init,
    output chacha_pkg::block_t keystream,
    output logic               done
);

    typedef enum logic [1:0] {
        G_IDLE,
        G_ROUND,
        G_FINAL
    } gen_state_t;

    gen_state_t                        state_reg, state_next;
    logic [chacha_pkg::ROUND_W-1:0]    round_reg, round_next;
    logic                              half_reg, half_next;
    logic                              done_reg, done_next;
    chacha_pkg::block_t                x_reg;
    chacha_pkg::block_t                ks_reg;
    chacha_pkg::block_t                round_out;

    chacha_round u_round (
        .x_in        (x_reg),
        .diag        (round_reg[0]),
        .second_half (half_reg),
        .x_out       (round_out)
    );

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        half_next  = half_reg;
        done_next  = 1'b0;
        case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    state_next = G_ROUND;
                    round_next = '0;
                    half_next  = 1'b0;
                end
            end
            G_ROUND:
            begin
                half_next = ~half_reg;
                if (half_reg)
                begin
                    if (round_reg == chacha_pkg::ROUND_W'(chacha_pkg::NUM_ROUNDS - 1))
                    begin
                        state_next = G_FINAL;
                    end
                    else
                    begin
                        round_next = round_reg + 1'b1;
                    end
                end
            end
            G_FINAL:
            begin
                state_next = G_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            round_reg <= '0;
            half_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            half_reg  <= half_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == G_IDLE && start)
        begin
            x_reg <= init;
        end
        else if (state_reg == G_ROUND)
        begin
            x_reg <= round_out;
        end
        if (state_reg == G_FINAL)
        begin
            for (int i = 0; i < 16; i++)
            begin
                ks_reg[i] <= x_reg[i] + init[i];
            end
        end
    end

    assign keystream = ks_reg;
    assign done      = done_reg;

endmodule

/* src/chacha20_stream_cipher_top.sv */
// Top level of the ChaCha20 stream cipher: configuration, word sequencing and output.
//
//  Channel  Role    Payload
//  plain    sink    data_in[31:0], byte_count[2:0], last_item
//  cipher   source  data_out[31:0], byte_count_out[2:0], last_out
//  cfg      sink    index[2:0], value[63:0]
//
// A word that opens a keystream block waits for 40 half-round steps of the shared round unit,
// then a feed-forward step, a handoff to the top level, and its emit into the output register.
// The other fifteen words of a block take their keystream word from the stored block.
// Reset clears configuration, counter, position and message state; the keystream is not reset.
// A stalled output holds its word while the next input word is already taken.
module chacha20_stream_cipher_top (
    input logic         clk,
    input logic         rst_n,
    chacha_in_if.sink   plain,
    chacha_out_if.source cipher,
    chacha_cfg_if.sink  cfg
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_GEN,
        T_EMIT
    } top_state_t;

    top_state_t                    state_reg;
    logic [63:0]                   key0_reg, key1_reg, key2_reg, key3_reg;
    logic [63:0]                   nonce_lo_reg;
    logic [31:0]                   nonce_hi_reg;
    logic [31:0]                   start_ctr_reg;
    logic [31:0]                   ctr_reg;
    logic [3:0]                    pos_reg;
    logic                          in_msg_reg;
    logic                          out_valid_reg;
    logic [31:0]                   out_data_reg;
    logic [chacha_pkg::CNT_W-1:0]  out_cnt_reg;
    logic                          out_last_reg;
    logic [31:0]                   data_reg;
    logic [chacha_pkg::CNT_W-1:0]  cnt_reg;
    logic                          last_reg;
    logic [3:0]                    idx_reg;

    logic                          accept;
    logic [3:0]                    pos_eff;
    logic [31:0]                   ctr_eff;
    logic                          need_block;
    logic                          gen_start;
    logic                          gen_done;
    logic                          emit;
    logic [31:0]                   mask;
    chacha_pkg::block_t            init;
    chacha_pkg::block_t            keystream;

    assign plain.ready = (state_reg == T_IDLE);
    assign accept      = plain.valid && plain.ready;
    assign pos_eff     = in_msg_reg ? pos_reg : 4'd0;
    assign ctr_eff     = in_msg_reg ? ctr_reg : start_ctr_reg;
    assign need_block  = (pos_eff == 4'd0);
    assign gen_start   = accept && need_block;
    assign emit        = (state_reg == T_EMIT) && (!out_valid_reg || cipher.ready);
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        init[0]  = chacha_pkg::SIGMA_0;
        init[1]  = chacha_pkg::SIGMA_1;
        init[2]  = chacha_pkg::SIGMA_2;
        init[3]  = chacha_pkg::SIGMA_3;
        init[4]  = key0_reg[31:0];
        init[5]  = key0_reg[63:32];
        init[6]  = key1_reg[31:0];
        init[7]  = key1_reg[63:32];
        init[8]  = key2_reg[31:0];
        init[9]  = key2_reg[63:32];
        init[10] = key3_reg[31:0];
        init[11] = key3_reg[63:32];
        init[12] = (state_reg == T_IDLE) ? ctr_eff : ctr_reg;
        init[13] = nonce_lo_reg[31:0];
        init[14] = nonce_lo_reg[63:32];
        init[15] = nonce_hi_reg;
    end

    always_comb
    begin
        case (cnt_reg) inside
            3'd0:         mask = 32'h00000000;
            3'd1:         mask = 32'h000000FF;
            3'd2:         mask = 32'h0000FFFF;
            3'd3:         mask = 32'h00FFFFFF;
            [3'd4:3'd7]:  mask = 32'hFFFFFFFF;
            default:      mask = 32'hFFFFFFFF;
        endcase
    end

    chacha_block_gen u_block_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (gen_start),
        .init      (init),
        .keystream (keystream),
        .done      (gen_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            key0_reg      <= '0;
            key1_reg      <= '0;
            key2_reg      <= '0;
            key3_reg      <= '0;
            nonce_lo_reg  <= '0;
            nonce_hi_reg  <= '0;
            start_ctr_reg <= '0;
            ctr_reg       <= '0;
            pos_reg       <= '0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    chacha_pkg::CFG_KEY_PART_0:    key0_reg      <= cfg.value;
                    chacha_pkg::CFG_KEY_PART_1:    key1_reg      <= cfg.value;
                    chacha_pkg::CFG_KEY_PART_2:    key2_reg      <= cfg.value;
                    chacha_pkg::CFG_KEY_PART_3:    key3_reg      <= cfg.value;
                    chacha_pkg::CFG_NONCE_LOW:     nonce_lo_reg  <= cfg.value;
                    chacha_pkg::CFG_NONCE_HIGH:    nonce_hi_reg  <= cfg.value[31:0];
                    chacha_pkg::CFG_START_COUNTER: start_ctr_reg <= cfg.value[31:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cipher.valid && cipher.ready && !emit)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        ctr_reg    <= ctr_eff;
                        pos_reg    <= pos_eff + 4'd1;
                        in_msg_reg <= !plain.last_item;
                        state_reg  <= need_block ? T_GEN : T_EMIT;
                    end
                end
                T_GEN:
                begin
                    if (gen_done)
                    begin
                        ctr_reg   <= ctr_reg + 32'd1;
                        state_reg <= T_EMIT;
                    end
                end
                T_EMIT:
                begin
                    if (emit)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= plain.data_in;
            cnt_reg  <= plain.byte_count;
            last_reg <= plain.last_item;
            idx_reg  <= pos_eff;
        end
        if (emit)
        begin
            out_data_reg <= (data_reg ^ keystream[idx_reg]) & mask;
            out_cnt_reg  <= cnt_reg;
            out_last_reg <= last_reg;
        end
    end

    assign cipher.valid          = out_valid_reg;
    assign cipher.data_out       = out_data_reg;
    assign cipher.byte_count_out = out_cnt_reg;
    assign cipher.last_out       = out_last_reg;

endmodule

/* src/chacha_checker.sv */
// Port-level assertions for the ChaCha20 stream cipher and their bind to the top level.
module chacha_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [31:0]                  out_data,
    input logic [chacha_pkg::CNT_W-1:0] out_count
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("A stalled output word changed or vanished.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("Input was ready again right after a transfer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_count == 3'd0 |-> out_data == 32'd0)
    else $error("A word with no valid bytes carried nonzero data.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_count == 3'd1 |-> out_data[31:8] == 24'd0)
    else $error("Bytes past a count of one were not zero.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_count == 3'd2 |-> out_data[31:16] == 16'd0)
    else $error("Bytes past a count of two were not zero.");

endmodule

bind chacha20_stream_cipher_top chacha_checker u_chacha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (plain.valid),
    .in_ready  (plain.ready),
    .out_valid (cipher.valid),
    .out_ready (cipher.ready),
    .out_data  (cipher.data_out),
    .out_count (cipher.byte_count_out)
);

/* dv/chacha20_stream_cipher_top_test.sv */
// Self-checking testbench for the ChaCha20 stream cipher top level with a built-in keystream predictor.
`timescale 1ns / 100ps

module chacha20_stream_cipher_top_test;

    localparam int NUM_PROBES      = 21;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 58;
    localparam int STEADY_PHASE    = 4;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int IDLE_PERCENT    = 28;
    localparam logic [chacha_pkg::CFG_IDX_W-1:0] CFG_INDEX_NONE = 3'd7;

    typedef struct packed {
        chacha_pkg::word_t              data;
        logic [chacha_pkg::CNT_W-1:0]   cnt;
        logic                           last;
    } stream_word_t;

    typedef struct packed {
        chacha_pkg::word_t              data;
        logic [chacha_pkg::CNT_W-1:0]   cnt;
        logic                           last;
        logic                           fixed;
        chacha_pkg::word_t              want;
    } probe_t;

    logic clk = 1'b0;
    logic rst_n;

    chacha_in_if  plain();
    chacha_out_if cipher();
    chacha_cfg_if cfg();

    chacha20_stream_cipher_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .plain  (plain),
        .cipher (cipher),
        .cfg    (cfg)
    );

    always #5 clk = ~clk;

    // Shadow copy of the cipher configuration and keystream state.
    logic [63:0]       key_q [4];
    logic [63:0]       nonce_lo_q;
    chacha_pkg::word_t nonce_hi_q;
    chacha_pkg::word_t start_ctr_q;
    chacha_pkg::word_t ks_q [16];
    logic [3:0]        pos_q;
    chacha_pkg::word_t ctr_q;
    bit                open_q;

    stream_word_t ciphertext_due [$];
    stream_word_t due_word;
    int           mismatches;
    int           cycles;
    int           phase_left;
    bit           steady;

    // Zero and oversize byte counts, short words inside a message and block crossings.
    probe_t probes [NUM_PROBES] = '{
        '{32'h0000_0000, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'hA5A5_A5A5, 3'd0, 1'b0, 1'b1, 32'h0},
        '{32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd2, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd3, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd5, 1'b0, 1'b0, 32'h0},
        '{32'h0F0F_0F0F, 3'd6, 1'b0, 1'b0, 32'h0},
        '{32'hF0F0_F0F0, 3'd7, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0001, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'h7FFF_FFFE, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'h0123_4567, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'h89AB_CDEF, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'hDEAD_BEEF, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0000, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'h1357_9BDF, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'h2468_ACE0, 3'd3, 1'b1, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, 32'h0},
        '{32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, 32'h0},
        '{32'h55AA_55AA, 3'd4, 1'b1, 1'b0, 32'h0}
    };

    function automatic chacha_pkg::word_t rotl(input chacha_pkg::word_t v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void mix_quarter(inout chacha_pkg::word_t a, inout chacha_pkg::word_t b,
                                        inout chacha_pkg::word_t c, inout chacha_pkg::word_t d);
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
    endfunction

    function automatic void refill_keystream();
        chacha_pkg::word_t s [16];
        chacha_pkg::word_t x [16];
        int                r;
        int                i;
        s[0]  = chacha_pkg::SIGMA_0; s[1]  = chacha_pkg::SIGMA_1;
        s[2]  = chacha_pkg::SIGMA_2; s[3]  = chacha_pkg::SIGMA_3;
        s[4]  = key_q[0][31:0];     s[5]  = key_q[0][63:32];
        s[6]  = key_q[1][31:0];     s[7]  = key_q[1][63:32];
        s[8]  = key_q[2][31:0];     s[9]  = key_q[2][63:32];
        s[10] = key_q[3][31:0];     s[11] = key_q[3][63:32];
        s[12] = ctr_q;
        s[13] = nonce_lo_q[31:0];   s[14] = nonce_lo_q[63:32];
        s[15] = nonce_hi_q;
        for (i = 0; i < 16; i++)
            x[i] = s[i];
        for (r = 0; r < chacha_pkg::NUM_ROUNDS / 2; r++)
        begin
            mix_quarter(x[0], x[4], x[8],  x[12]);
            mix_quarter(x[1], x[5], x[9],  x[13]);
            mix_quarter(x[2], x[6], x[10], x[14]);
            mix_quarter(x[3], x[7], x[11], x[15]);
            mix_quarter(x[0], x[5], x[10], x[15]);
            mix_quarter(x[1], x[6], x[11], x[12]);
            mix_quarter(x[2], x[7], x[8],  x[13]);
            mix_quarter(x[3], x[4], x[9],  x[14]);
        end
        for (i = 0; i < 16; i++)
            ks_q[i] = x[i] + s[i];
    endfunction

    function automatic stream_word_t encrypt_word(input stream_word_t w);
        stream_word_t      r;
        chacha_pkg::word_t mask;
        if (!open_q)
        begin
            ctr_q = start_ctr_q;
            pos_q = 4'd0;
        end
        if (pos_q == 4'd0)
        begin
            refill_keystream();
            ctr_q = ctr_q + 32'd1;
        end
        mask   = (w.cnt >= 3'd4) ? 32'hFFFF_FFFF : (32'd1 << (8 * w.cnt)) - 32'd1;
        r.data = (w.data ^ ks_q[pos_q]) & mask;
        r.cnt  = w.cnt;
        r.last = w.last;
        pos_q  = pos_q + 4'd1;
        open_q = !w.last;
        return r;
    endfunction

    function automatic void apply_reg(input logic [chacha_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [63:0] v);
        case (idx)
            chacha_pkg::CFG_KEY_PART_0:    key_q[0]    = v;
            chacha_pkg::CFG_KEY_PART_1:    key_q[1]    = v;
            chacha_pkg::CFG_KEY_PART_2:    key_q[2]    = v;
            chacha_pkg::CFG_KEY_PART_3:    key_q[3]    = v;
            chacha_pkg::CFG_NONCE_LOW:     nonce_lo_q  = v;
            chacha_pkg::CFG_NONCE_HIGH:    nonce_hi_q  = v[31:0];
            chacha_pkg::CFG_START_COUNTER: start_ctr_q = v[31:0];
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [chacha_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] v);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.value = v;
        do @(posedge clk); while (!cfg.ready);
        apply_reg(idx, v);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic send_word(input stream_word_t w, input bit fixed, input stream_word_t want);
        stream_word_t predicted;
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            plain.valid = 1'b0;
            @(negedge clk);
        end
        plain.valid      = 1'b1;
        plain.data_in    = w.data;
        plain.byte_count = w.cnt;
        plain.last_item  = w.last;
        do @(posedge clk); while (!plain.ready);
        predicted = encrypt_word(w);
        ciphertext_due.push_back(fixed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        plain.valid = 1'b0;
        while (ciphertext_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Most messages are well formed; a noisy one mixes in odd counts and early last flags.
    task automatic send_message(input int len);
        stream_word_t w;
        bit           noisy;
        int           k;
        noisy = ($urandom_range(99) < 15);
        for (k = 0; k < len && phase_left > 0; k++)
        begin
            w.data = $urandom();
            w.last = (k == len - 1);
            if (noisy)
            begin
                w.cnt = chacha_pkg::CNT_W'($urandom_range(7));
                if ($urandom_range(9) == 0)
                    w.last = 1'b1;
            end
            else
                w.cnt = w.last ? chacha_pkg::CNT_W'($urandom_range(1, 4)) : 3'd4;
            send_word(w, 1'b0, w);
            phase_left--;
        end
    endtask

    task automatic setup_phase(input int p);
        logic [63:0] v;
        logic [3:0]  idx;
        for (idx = 4'(chacha_pkg::CFG_KEY_PART_0); idx <= 4'(chacha_pkg::CFG_START_COUNTER);
             idx++)
        begin
            if (p == 0)
                v = '1;
            else if (p == 1)
                v = '0;
            else
            begin
                if (p > 2 && $urandom_range(99) < 40)
                    continue;
                case ($urandom_range(3))
                    0:       v = '0;
                    1:       v = '1;
                    default: v = {$urandom(), $urandom()};
                endcase
            end
            write_reg(idx[chacha_pkg::CFG_IDX_W-1:0], v);
        end
        if (p == 1 || $urandom_range(3) == 0)
            write_reg(CFG_INDEX_NONE, {$urandom(), $urandom()});
    endtask

    always @(negedge clk)
        cipher.ready = steady || ($urandom_range(99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        if (rst_n && cipher.valid && cipher.ready)
        begin
            if (ciphertext_due.size() == 0)
            begin
                $display("%0t: unexpected transfer, data_out %h byte_count_out %0d last_out %0b",
                         $time, cipher.data_out, cipher.byte_count_out, cipher.last_out);
                mismatches++;
            end
            else
            begin
                due_word = ciphertext_due.pop_front();
                if (cipher.data_out !== due_word.data)
                begin
                    $display("%0t: data_out expected %h actual %h",
                             $time, due_word.data, cipher.data_out);
                    mismatches++;
                end
                if (cipher.byte_count_out !== due_word.cnt)
                begin
                    $display("%0t: byte_count_out expected %0d actual %0d",
                             $time, due_word.cnt, cipher.byte_count_out);
                    mismatches++;
                end
                if (cipher.last_out !== due_word.last)
                begin
                    $display("%0t: last_out expected %0b actual %0b",
                             $time, due_word.last, cipher.last_out);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        stream_word_t w;
        stream_word_t want;
        int           i;
        int           p;
        int           len;
        bit           first;
        mismatches = 0;
        cycles     = 0;
        steady     = 1'b0;
        for (i = 0; i < 4; i++)
            key_q[i] = '0;
        nonce_lo_q  = '0;
        nonce_hi_q  = '0;
        start_ctr_q = '0;
        pos_q       = '0;
        ctr_q       = '0;
        open_q      = 1'b0;
        rst_n            = 1'b0;
        plain.valid      = 1'b0;
        plain.data_in    = '0;
        plain.byte_count = '0;
        plain.last_item  = 1'b0;
        cipher.ready     = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = '0;
        cfg.value        = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < NUM_PROBES; i++)
        begin
            w.data    = probes[i].data;
            w.cnt     = probes[i].cnt;
            w.last    = probes[i].last;
            want      = w;
            want.data = probes[i].want;
            send_word(w, probes[i].fixed, want);
        end
        wait_idle();

        // Phases may close with a message still open, so later writes land mid-message.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            steady = (p == STEADY_PHASE);
            setup_phase(p);
            phase_left = ITEMS_PER_PHASE;
            first      = 1'b1;
            while (phase_left > 0)
            begin
                if (p == 0 && first)
                    len = 40;
                else if ($urandom_range(9) == 0)
                    len = $urandom_range(41, 80);
                else
                    len = $urandom_range(1, 40);
                first = 1'b0;
                send_message(len);
            end
            wait_idle();
        end
        steady = 1'b0;

        repeat (100) @(negedge clk);
        if (ciphertext_due.size() != 0)
        begin
            $display("%0t: %0d expected transfers never arrived", $time, ciphertext_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* chacha20_stream_cipher_top.f */
src/chacha_pkg.sv
src/chacha_if.sv
src/chacha_round.sv
src/chacha_block_gen.sv
src/chacha20_stream_cipher_top.sv
src/chacha_checker.sv
dv/chacha20_stream_cipher_top_test.sv
